// ----- hdl/one_shot_timer_bank_assert.svh -----
// Assertion macros for the one-shot timer bank checker.
// Depends on nothing; expects clk and rst in the scope that uses them.
`ifndef ONE_SHOT_TIMER_BANK_ASSERT_SVH
`define ONE_SHOT_TIMER_BANK_ASSERT_SVH

// Clocked check, switched off while reset is held.
`define OSTB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define OSTB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/ostb_pkg.sv -----
// Shared types and constants for the one-shot timer bank.
// No dependencies.
package ostb_pkg;

  localparam int SLOT_COUNT_DEF = 8;
  localparam int CMD_W          = 3;
  localparam int SLOT_W         = 3;
  localparam int DELAY_W        = 16;
  localparam int MASK_W         = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 3'd0,
    CMD_ARM    = 3'd1,
    CMD_REARM  = 3'd2,
    CMD_FIRE   = 3'd3,
    CMD_CANCEL = 3'd4
  } cmd_t;

  // Per-slot control from the command decoder
  typedef struct packed {
    logic tick;
    logic load;
    logic clear;
  } slot_cmd_t;

endpackage

// ----- hdl/ostb_slot.sv -----
// One countdown slot: 16-bit down counter with load, clear and tick.
// Depends on ostb_pkg.
module ostb_slot
  import ostb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  slot_cmd_t          ctl,
  input  logic [DELAY_W-1:0] load_value,
  output logic               nonzero,
  output logic               expire
);

  logic [DELAY_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.clear) begin
      count <= '0;
    end else if (ctl.load) begin
      count <= load_value;
    end else if (ctl.tick && nonzero) begin
      count <= count - DELAY_W'(1);
    end
  end

  assign nonzero = |count;
  // reaches zero on the next tick
  assign expire  = (count == DELAY_W'(1));

endmodule

// ----- hdl/ostb_ctrl.sv -----
// Command decode, pending bits, ticking flag and result register.
// Depends on ostb_pkg; drives the ostb_slot counters.
module ostb_ctrl
  import ostb_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  cmd_t               in_cmd,
  input  logic [SLOT_W-1:0]  in_slot,
  input  logic [DELAY_W-1:0] in_delay,
  input  logic [MASK_W-1:0]  registered_slots,
  input  logic [SLOT_COUNT-1:0] nonzero,
  input  logic [SLOT_COUNT-1:0] expire,
  output slot_cmd_t          slot_ctl [SLOT_COUNT],
  output logic               done,
  output logic               status,
  output logic [MASK_W-1:0]  fired_slots,
  output logic [MASK_W-1:0]  pending_slots
);

  localparam int WIDE = (SLOT_COUNT > MASK_W) ? SLOT_COUNT : MASK_W;

  logic [SLOT_COUNT-1:0] pending, pending_next;
  logic                  ticking, ticking_next;
  logic [SLOT_COUNT-1:0] fired;
  logic [SLOT_COUNT-1:0] sel_mask;
  logic [WIDE-1:0]       pend_wide, nz_wide, pend_next_wide, fired_wide;
  logic                  in_range, sel_pend, sel_reg, live, delay_zero;
  logic                  reject, sweep, do_load, do_clear;

  assign in_range   = (32'(in_slot) < SLOT_COUNT);
  assign sel_mask   = SLOT_COUNT'(1) << in_slot;
  assign pend_wide  = WIDE'(pending);
  assign nz_wide    = WIDE'(nonzero);
  assign sel_pend   = pend_wide[in_slot];
  assign sel_reg    = registered_slots[in_slot];
  assign delay_zero = (in_delay == '0);
  // shared by re-arm and fire now
  assign live       = ticking && sel_pend && sel_reg && nz_wide[in_slot];

  always_comb begin
    reject       = 1'b0;
    fired        = '0;
    pending_next = pending;
    ticking_next = ticking;
    sweep        = 1'b0;
    do_load      = 1'b0;
    do_clear     = 1'b0;
    if (in_valid) begin
      case (in_cmd)
        CMD_TICK: begin
          sweep        = 1'b1;
          fired        = expire;
          pending_next = pending & ~expire;
        end
        CMD_ARM: begin
          if (!in_range) begin
            reject = 1'b1;
          end else begin
            ticking_next = 1'b1;
            if (delay_zero || sel_pend || !sel_reg) begin
              reject = 1'b1;
            end else begin
              do_load      = 1'b1;
              pending_next = pending | sel_mask;
            end
          end
        end
        CMD_REARM: begin
          if (!in_range || !live || delay_zero) begin
            reject = 1'b1;
          end else begin
            do_load = 1'b1;
          end
        end
        CMD_FIRE: begin
          if (!in_range || !live) begin
            reject = 1'b1;
          end else begin
            do_clear     = 1'b1;
            pending_next = pending & ~sel_mask;
            fired        = sel_mask;
          end
        end
        CMD_CANCEL: begin
          if (!in_range) begin
            reject = 1'b1;
          end else begin
            do_clear     = 1'b1;
            pending_next = pending & ~sel_mask;
          end
        end
        default: begin
          reject = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_ctl[i].tick  = sweep;
      slot_ctl[i].load  = do_load && (32'(in_slot) == i);
      slot_ctl[i].clear = do_clear && (32'(in_slot) == i);
    end
  end

  assign pend_next_wide = WIDE'(pending_next);
  assign fired_wide     = WIDE'(fired);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      ticking <= 1'b0;
      done    <= 1'b0;
    end else begin
      pending <= pending_next;
      ticking <= ticking_next;
      done    <= in_valid;
    end
    status        <= reject;
    fired_slots   <= fired_wide[MASK_W-1:0];
    pending_slots <= pend_next_wide[MASK_W-1:0];
  end

endmodule

// ----- hdl/one_shot_timer_bank.sv -----
// One-shot timer bank, top level: input register, slot register and the bank.
// Depends on ostb_pkg, ostb_slot and ostb_ctrl.
//
// Usage
//   Commands: drive command, slot and delay_ms with start high; the command
//   is taken at a rising edge with start high and busy low. busy is never
//   raised, so one command can be transferred every cycle.
//   Results: after the input register and then the result register (which
//   also updates the slot counters and pending bits), done is high for
//   exactly one cycle with status, fired_slots and pending_slots. The
//   receiver cannot hold a result back; results leave in command order,
//   one per command. Throughput: one command per cycle, set by the single
//   decode-and-update step that each command's effect must finish before
//   the next command reads the state.
//   Configuration: cfg_write loads cfg_data into the registered-slots mask
//   at the same edge; write it only with no command in flight.
//   Reset (rst, synchronous): counters, pending bits, the ticking flag, the
//   registered-slots mask and done are cleared.
module one_shot_timer_bank
  import ostb_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [CMD_W-1:0]   command,
  input  logic [SLOT_W-1:0]  slot,
  input  logic [DELAY_W-1:0] delay_ms,
  input  logic               cfg_write,
  input  logic [MASK_W-1:0]  cfg_data,
  output logic               done,
  output logic               status,
  output logic [MASK_W-1:0]  fired_slots,
  output logic [MASK_W-1:0]  pending_slots
);

  logic               in_valid;
  cmd_t               in_cmd;
  logic [SLOT_W-1:0]  in_slot;
  logic [DELAY_W-1:0] in_delay;
  logic [MASK_W-1:0]  registered_slots;

  logic [SLOT_COUNT-1:0] nonzero;
  logic [SLOT_COUNT-1:0] expire;
  slot_cmd_t             slot_ctl [SLOT_COUNT];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid         <= 1'b0;
      registered_slots <= '0;
    end else begin
      in_valid <= start && !busy;
      if (cfg_write) begin
        registered_slots <= cfg_data;
      end
    end
    in_cmd   <= cmd_t'(command);
    in_slot  <= slot;
    in_delay <= delay_ms;
  end

  ostb_ctrl #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_cmd           (in_cmd),
    .in_slot          (in_slot),
    .in_delay         (in_delay),
    .registered_slots (registered_slots),
    .nonzero          (nonzero),
    .expire           (expire),
    .slot_ctl         (slot_ctl),
    .done             (done),
    .status           (status),
    .fired_slots      (fired_slots),
    .pending_slots    (pending_slots)
  );

  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_slot
    ostb_slot u_slot (
      .clk        (clk),
      .rst        (rst),
      .ctl        (slot_ctl[g]),
      .load_value (in_delay),
      .nonzero    (nonzero[g]),
      .expire     (expire[g])
    );
  end

endmodule

// ----- hdl/ostb_checker.sv -----
// Port-level checks for the one-shot timer bank, bound to the top level.
// Depends on ostb_pkg and one_shot_timer_bank_assert.svh.
`include "one_shot_timer_bank_assert.svh"

module ostb_checker
  import ostb_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic              status,
  input logic [MASK_W-1:0] fired_slots,
  input logic [MASK_W-1:0] pending_slots
);

  `OSTB_ASSERT(a_result_follows, start && !busy |=> ##1 done, "transfer gave no result")
  `OSTB_ASSERT(a_result_has_cause, done |-> $past(start, 2) && !$past(rst, 1) && !$past(rst, 2), "result without transfer")
  `OSTB_ASSERT(a_reject_quiet, done && status |-> fired_slots == '0, "rejected command fired")
  `OSTB_ASSERT_ALWAYS(a_fired_not_pending, done |-> (fired_slots & pending_slots) == '0, "fired slot still pending")

endmodule

bind one_shot_timer_bank ostb_checker u_ostb_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .status        (status),
  .fired_slots   (fired_slots),
  .pending_slots (pending_slots)
);
